@@ rtl/websocket_frame_parser_core_defines.svh @@
// Assertion macros shared by the frame parser RTL.
// Expects signals named clock and reset in the including module.
`ifndef WEBSOCKET_FRAME_PARSER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define WSFP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSFP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wsfp_pkg.sv @@
// Shared types and constants for the WebSocket frame parser.
// No dependencies.
package wsfp_pkg;

   localparam int LEN_W   = 64;
   localparam int PLEN_W  = 64;
   localparam int TDATA_W = 120;
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_PAY = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_TRUNC  = 2'd1;
   localparam logic [1:0] ERR_OPCODE = 2'd2;

   localparam logic [3:0] OP_CONT         = 4'h0;
   localparam logic [3:0] OP_TEXT         = 4'h1;
   localparam logic [3:0] OP_BINARY       = 4'h2;
   localparam logic [3:0] OP_DATA_RSVD_LO = 4'h3;
   localparam logic [3:0] OP_DATA_RSVD_HI = 4'h7;
   localparam logic [3:0] OP_CLOSE        = 4'h8;
   localparam logic [3:0] OP_PING         = 4'h9;
   localparam logic [3:0] OP_PONG         = 4'hA;
   localparam logic [3:0] OP_CTRL_RSVD_LO = 4'hB;
   localparam logic [3:0] OP_CTRL_RSVD_HI = 4'hF;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [4:0] {
      PH_BYTE0   = 5'b00001,
      PH_BYTE1   = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_KEY     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              fin;
      logic [2:0]        rsv_bits;
      logic [3:0]        opcode;
      logic              masked;
      logic [PLEN_W-1:0] payload_length;
      logic [31:0]       frame_key;
      logic [7:0]        payload_out;
      logic              last_of_frame;
      logic [1:0]        error_code;
   } res_type;

   typedef struct packed {
      logic    push_a;
      logic    push_b;
      res_type a;
      res_type b;
   } push_type;

endpackage

@@ rtl/websocket_frame_parser_core.sv @@
// WebSocket (RFC 6455) frame parser: one received byte per beat in, header, payload
// and error results out. Accepts one byte per cycle, while req_tready is high, into an
// input register; the byte is parsed from that register once the queue has room, and its
// results are written to a four-entry queue whose head drives rsp.
// req_tready drops only while the input register holds a byte and fewer than two queue
// slots are free. A byte that ends a buffer in mid-frame right after a header or payload
// result yields two results, so a slow or one-per-cycle rsp side can stall the input.
// Depends on wsfp_pkg, wsfp_parser and wsfp_result_fifo.
module websocket_frame_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // data_byte
   input  logic                           req_tlast,  // end_of_buffer
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fin, rsv_bits, opcode, masked, payload_length, key, payload_out, error_code
   output logic [wsfp_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // kind
   output logic                           rsp_tlast,  // last_of_frame
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data    // unmask_enable
);
   import wsfp_pkg::*;

   logic       stg_valid_ff, stg_valid_in;
   logic [7:0] stg_byte_ff;
   logic       stg_eob_ff;
   logic       unmask_ff, unmask_in;
   logic       room, adv, req_beat;
   push_type   push;
   res_type    rsp;

   assign adv        = stg_valid_ff && room;
   assign req_tready = !stg_valid_ff || room;
   assign req_beat   = req_tvalid && req_tready;
   assign stg_valid_in = req_beat || (stg_valid_ff && !adv);

   assign csr_ready = 1'b1;
   assign unmask_in = (csr_valid && csr_ready) ? csr_data : unmask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         unmask_ff    <= 1'b1;
      end else begin
         stg_valid_ff <= stg_valid_in;
         unmask_ff    <= unmask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         stg_byte_ff <= req_tdata;
         stg_eob_ff  <= req_tlast;
      end
   end

   wsfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (adv),
      .data_byte     (stg_byte_ff),
      .end_of_buffer (stg_eob_ff),
      .unmask_enable (unmask_ff),
      .push          (push)
   );

   wsfp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp       (rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {5'b0, rsp.error_code, rsp.payload_out, rsp.frame_key,
                       rsp.payload_length, rsp.masked, rsp.opcode, rsp.rsv_bits, rsp.fin};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last_of_frame;

endmodule

@@ rtl/wsfp_parser.sv @@
// Per-byte frame parsing step: header phases, length, key, unmasking.
// Depends on wsfp_pkg and the assertion macro header.
`include "websocket_frame_parser_core_defines.svh"

module wsfp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         data_byte,
   input  logic               end_of_buffer,
   input  logic               unmask_enable,
   output wsfp_pkg::push_type push
);
   import wsfp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        fhb_ff, fhb_in;
   logic              mask_ff, mask_in;
   logic [LEN_W-1:0]  acc_ff, acc_in;
   logic [3:0]        left_ff, left_in;
   logic [31:0]       key_ff, key_in;
   logic [1:0]        kidx_ff, kidx_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;

   logic       hdr, fs;
   logic [6:0] l7;
   logic [7:0] kbyte;
   logic       last;

   function automatic res_type mk_res(input logic [1:0] kind, input logic [7:0] fhb,
                                      input logic msk, input logic [LEN_W-1:0] plen,
                                      input logic [31:0] key, input logic [7:0] pay,
                                      input logic lst, input logic [1:0] err);
      res_type r;
      r.kind           = kind;
      r.fin            = fhb[7];
      r.rsv_bits       = fhb[6:4];
      r.opcode         = fhb[3:0];
      r.masked         = msk;
      r.payload_length = PLEN_W'(plen);
      r.frame_key      = key;
      r.payload_out    = pay;
      r.last_of_frame  = lst;
      r.error_code     = err;
      return r;
   endfunction

   assign l7 = data_byte[6:0];

   always_comb begin
      case (kidx_ff)
         2'd0:    kbyte = key_ff[31:24];
         2'd1:    kbyte = key_ff[23:16];
         2'd2:    kbyte = key_ff[15:8];
         default: kbyte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      fhb_in   = fhb_ff;
      mask_in  = mask_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      key_in   = key_ff;
      kidx_in  = kidx_ff;
      rem_in   = rem_ff;
      hdr      = 1'b0;
      fs       = 1'b0;
      last     = 1'b0;
      push     = '0;

      case (phase_ff)
         PH_BYTE0: begin
            fhb_in   = data_byte;
            mask_in  = 1'b0;
            acc_in   = '0;
            left_in  = '0;
            key_in   = '0;
            kidx_in  = '0;
            rem_in   = '0;
            phase_in = PH_BYTE1;
         end
         PH_BYTE1: begin
            if (fhb_ff[3:0] inside {[OP_DATA_RSVD_LO:OP_DATA_RSVD_HI],
                                    [OP_CTRL_RSVD_LO:OP_CTRL_RSVD_HI]}) begin
               push.push_a = 1'b1;
               push.a = mk_res(KIND_ERR, fhb_ff, 1'b0, '0, '0, '0, 1'b1, ERR_OPCODE);
               fs = 1'b1;
            end else begin
               mask_in = data_byte[7];
               if (l7 == LEN7_EXT16 || l7 == LEN7_EXT64) begin
                  acc_in   = '0;
                  left_in  = (l7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end else begin
                  acc_in = LEN_W'(l7);
                  if (data_byte[7]) begin
                     key_in   = '0;
                     kidx_in  = '0;
                     left_in  = KEY_BYTES;
                     phase_in = PH_KEY;
                  end else begin
                     hdr = 1'b1;
                  end
               end
            end
         end
         PH_EXTLEN: begin
            if (acc_ff > (LEN_MAX >> 8)) acc_in = LEN_MAX;
            else acc_in = {acc_ff[LEN_W-9:0], data_byte};
            left_in = left_ff - 4'd1;
            if (left_in == 4'd0) begin
               if (mask_ff) begin
                  key_in   = '0;
                  kidx_in  = '0;
                  left_in  = KEY_BYTES;
                  phase_in = PH_KEY;
               end else begin
                  hdr = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in  = {key_ff[23:0], data_byte};
            kidx_in = kidx_ff + 2'd1;
            left_in = left_ff - 4'd1;
            if (left_in == 4'd0) hdr = 1'b1;
         end
         PH_PAYLOAD: begin
            kidx_in = kidx_ff + 2'd1;
            rem_in  = rem_ff - LEN_W'(1);
            last    = (rem_ff == LEN_W'(1));
            push.push_a = 1'b1;
            push.a = mk_res(KIND_PAY, fhb_ff, mask_ff, '0, '0,
                            (mask_ff && unmask_enable) ? (data_byte ^ kbyte) : data_byte,
                            last, ERR_NONE);
            fs = last;
         end
         default: begin
            fs = 1'b1;
         end
      endcase

      if (hdr) begin
         push.push_a = 1'b1;
         push.a = mk_res(KIND_HDR, fhb_in, mask_in, acc_in, mask_in ? key_in : 32'd0,
                         '0, (acc_in == '0), ERR_NONE);
         if (acc_in == '0) begin
            fs = 1'b1;
         end else begin
            rem_in   = acc_in;
            kidx_in  = '0;
            phase_in = PH_PAYLOAD;
         end
      end

      if (fs) phase_in = PH_BYTE0;

      // truncated frame at end of buffer
      if (end_of_buffer && phase_in != PH_BYTE0) begin
         if (push.push_a) begin
            push.push_b = 1'b1;
            push.b = mk_res(KIND_ERR, fhb_in, 1'b0, '0, '0, '0, 1'b1, ERR_TRUNC);
         end else begin
            push.push_a = 1'b1;
            push.a = mk_res(KIND_ERR, fhb_in, 1'b0, '0, '0, '0, 1'b1, ERR_TRUNC);
         end
         fs       = 1'b1;
         phase_in = PH_BYTE0;
      end

      if (fs) begin
         mask_in = 1'b0;
         acc_in  = '0;
         left_in = '0;
         key_in  = '0;
         kidx_in = '0;
         rem_in  = '0;
      end

      if (!step_en) begin
         push.push_a = 1'b0;
         push.push_b = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BYTE0;
         fhb_ff   <= '0;
         mask_ff  <= 1'b0;
         acc_ff   <= '0;
         left_ff  <= '0;
         key_ff   <= '0;
         kidx_ff  <= '0;
         rem_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         fhb_ff   <= fhb_in;
         mask_ff  <= mask_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         key_ff   <= key_in;
         kidx_ff  <= kidx_in;
         rem_ff   <= rem_in;
      end
   end

   `WSFP_ASSERT_IMP(a_payload_beat, step_en && phase_ff == PH_PAYLOAD, push.push_a && push.a.kind == KIND_PAY, "payload byte without payload result")
   `WSFP_ASSERT_IMP(a_second_is_trunc, push.push_b, push.push_a && push.b.error_code == ERR_TRUNC && end_of_buffer, "second result is not a truncation")
   `WSFP_ASSERT_NXT(a_payload_nonzero, step_en && phase_in == PH_PAYLOAD, rem_ff != '0, "payload phase with zero bytes left")

endmodule

@@ rtl/wsfp_result_fifo.sv @@
// Four-entry result queue, up to two writes and one read per cycle.
// Depends on wsfp_pkg and the assertion macro header.
`include "websocket_frame_parser_core_defines.svh"

module wsfp_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  wsfp_pkg::push_type push,
   output logic               room,
   output wsfp_pkg::res_type  rsp,
   output logic               rsp_valid,
   input  logic               rsp_ready
);
   import wsfp_pkg::*;

   res_type          mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]  count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (count_ff <= Q_CW'(Q_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + Q_AW'(push.push_a) + Q_AW'(push.push_b);
   assign rd_ptr_in = rd_ptr_ff + Q_AW'(pop);
   assign count_in  = count_ff + Q_CW'(push.push_a) + Q_CW'(push.push_b) - Q_CW'(pop);

   always_ff @(posedge clock) begin
      if (push.push_a) mem_ff[wr_ptr_ff] <= push.a;
      if (push.push_b) mem_ff[wr_ptr_ff + Q_AW'(1)] <= push.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `WSFP_ASSERT_IMP(a_no_overflow, push.push_a, room, "push without two free slots")
   `WSFP_ASSERT_IMP(a_b_after_a, push.push_b, push.push_a, "second slot written alone")
   `WSFP_ASSERT_NXT(a_pop_count, pop && !push.push_a, count_ff == $past(count_ff) - Q_CW'(1), "count lost a pop")

endmodule
